// ===== rtl/core/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// shared constants and codes for the stream listener registry
// ----------------------------------------------------------------------------
package slr_pkg;

  localparam int unsigned TABLE_SLOTS_DEFAULT = 16;

  localparam int unsigned SID_W    = 64;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned SHOWN_W  = 5;
  localparam int unsigned SHOWN_MAX = 31;

  // attribute type
  localparam logic [CODE_W-1:0] CMD_LISTENER = 2'd0;
  localparam logic [CODE_W-1:0] CMD_TALKER   = 2'd1;

  // notice kind
  localparam logic [CODE_W-1:0] KIND_NEW   = 2'd0;
  localparam logic [CODE_W-1:0] KIND_JOIN  = 2'd1;
  localparam logic [CODE_W-1:0] KIND_LEAVE = 2'd2;

  // listener declaration
  localparam logic [CODE_W-1:0] DECL_READY        = 2'd2;
  localparam logic [CODE_W-1:0] DECL_READY_FAILED = 2'd3;

  // result status
  localparam logic [CODE_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [CODE_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [CODE_W-1:0] ST_NOCHANGE = 2'd2;
  localparam logic [CODE_W-1:0] ST_FULL     = 2'd3;

endpackage

// ===== rtl/core/slr_ram.sv =====
// ----------------------------------------------------------------------------
// slr_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module slr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/stream_listener_registry_unit.sv =====
// ----------------------------------------------------------------------------
// stream_listener_registry_unit
// listener table and talker flag for one tracked stream id
// ----------------------------------------------------------------------------
// Tracks stream-reservation notifications for the stream id written through
// the configuration port. Listener addresses live in a TABLE_SLOTS-entry ram;
// a flop per slot marks it occupied, so reset needs no clearing pass. A
// listener leave, or a listener add with a ready or ready-failed declaration,
// for the tracked stream walks the ram one slot per cycle: a leave frees the
// slot holding the address, such an add stores the address in the lowest free
// slot unless it is present or the table is full. Each item gives exactly one
// result (status, listener count saturated at 31, sticky talker flag). The
// walk uses the single ram read port once over the table, followed by the
// compare and the result; every other item goes straight to the result. A
// finished result waits while an earlier result is held by out_stall. One
// item is in work at a time; the output register lets a new item be accepted
// while the previous result waits. Configuration is to be written by the
// user only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module stream_listener_registry_unit
  import slr_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SID_W-1:0]    own_stream_id,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CODE_W-1:0]   command,
  input  logic [CODE_W-1:0]   notice_kind,
  input  logic [CODE_W-1:0]   declaration,
  input  logic [SID_W-1:0]    stream_id,
  input  logic [ADDR_W-1:0]   registrar_address,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   status,
  output logic [SHOWN_W-1:0]  listener_count,
  output logic                talker_seen
);

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned EXT_W = (CNT_W > SHOWN_W) ? CNT_W : SHOWN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_JOIN,
    OP_LEAVE
  } op_t;

  state_t state;
  op_t    op;

  // configuration register
  logic [SID_W-1:0]  tracked_sid;

  // captured item
  logic [ADDR_W-1:0] req_addr;

  // table state
  logic [TABLE_SLOTS-1:0] slot_used;
  logic [CNT_W-1:0]       attached_count;
  logic                   talker_flag;

  // scan control
  logic             issue;
  logic [IDX_W-1:0] rd_idx;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // ram ports
  logic              rd_en;
  logic              wr_en;
  logic [ADDR_W-1:0] rd_data;

  // combinational helpers
  logic              in_accept;
  logic              sid_match;
  logic              load;
  logic              chk_hit;
  logic [CODE_W-1:0] status_next;
  logic [CNT_W-1:0]  count_next;
  logic [EXT_W-1:0]  count_ext;
  logic [SHOWN_W-1:0] shown_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign sid_match = (stream_id == tracked_sid);

  // one ram read per cycle while walking the table
  assign rd_en   = (state == S_SCAN) && issue;
  assign chk_hit = chk_valid && slot_used[chk_idx] && (rd_data == req_addr);

  // result and writeback leave together with the output register load
  assign load  = (state == S_FINISH) && (!out_valid || !out_stall);
  assign wr_en = load && (op == OP_JOIN) && !hit && free_found;

  always_comb begin
    status_next = ST_NOCHANGE;
    count_next  = attached_count;
    unique case (op)
      OP_JOIN: begin
        if (hit) begin
          status_next = ST_NOCHANGE;
        end else if (free_found) begin
          status_next = ST_ADDED;
          count_next  = attached_count + CNT_W'(1);
        end else begin
          status_next = ST_FULL;
        end
      end
      OP_LEAVE: begin
        if (hit) begin
          status_next = ST_REMOVED;
          count_next  = attached_count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_NOCHANGE;
      end
    endcase
    // saturate the shown count at the field's range
    count_ext  = EXT_W'(count_next);
    shown_next = (count_ext > EXT_W'(SHOWN_MAX)) ? SHOWN_W'(SHOWN_MAX)
                                                 : count_ext[SHOWN_W-1:0];
  end

  slr_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TABLE_SLOTS)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (req_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_NONE;
      tracked_sid    <= '0;
      slot_used      <= '0;
      attached_count <= '0;
      talker_flag    <= 1'b0;
      issue          <= 1'b0;
      rd_idx         <= '0;
      chk_valid      <= 1'b0;
      chk_idx        <= '0;
      hit            <= 1'b0;
      hit_idx        <= '0;
      free_found     <= 1'b0;
      free_idx       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tracked_sid <= own_stream_id;
      end

      // output register drains independently of the scan
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      chk_valid <= rd_en;
      chk_idx   <= rd_idx;

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_addr   <= registrar_address;
            issue      <= 1'b1;
            rd_idx     <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            // talker announce for our stream is sticky
            if (command == CMD_TALKER && sid_match &&
                (notice_kind == KIND_NEW || notice_kind == KIND_JOIN)) begin
              talker_flag <= 1'b1;
            end
            if (command == CMD_LISTENER && sid_match &&
                notice_kind == KIND_LEAVE) begin
              op    <= OP_LEAVE;
              state <= S_SCAN;
            end else if (command == CMD_LISTENER && sid_match &&
                         (declaration == DECL_READY ||
                          declaration == DECL_READY_FAILED)) begin
              op    <= OP_JOIN;
              state <= S_SCAN;
            end else begin
              op    <= OP_NONE;
              state <= S_FINISH;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            if (rd_idx == LAST_IDX) begin
              issue <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IDX_W'(1);
            end
          end
          // compare one slot per cycle, in the cycle after its read
          if (chk_hit) begin
            hit     <= 1'b1;
            hit_idx <= chk_idx;
          end
          if (chk_valid && !slot_used[chk_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          if (chk_valid && chk_idx == LAST_IDX) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load) begin
            status         <= status_next;
            listener_count <= shown_next;
            talker_seen    <= talker_flag;
            attached_count <= count_next;
            if (op == OP_JOIN && !hit && free_found) begin
              slot_used[free_idx] <= 1'b1;
            end
            if (op == OP_LEAVE && hit) begin
              slot_used[hit_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // live count always matches the occupied slots
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    int'(attached_count) == $countones(slot_used))
    else $error("attached count differs from occupied slots");

  // talker flag never falls once set
  a_talker_sticky: assert property (@(posedge clk) disable iff (rst)
    talker_flag |=> talker_flag)
    else $error("talker flag cleared");

  // table only changes when a result is loaded
  a_table_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(slot_used))
    else $error("slot occupancy changed without a result");

  // ram compare data only arrives while walking the table
  a_chk_in_scan: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (state == S_SCAN))
    else $error("compare outside of a table walk");

endmodule
